[design/tts_pkg.sv]
// ============================================================================
// tts_pkg
// Shared types and constants for the tick task scheduler table.
// ============================================================================
package tts_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int HANDLE_W = 16;
   localparam int COUNT_W  = 16;
   localparam int INDEX_W  = 4;

   localparam logic [COUNT_W-1:0] CD_WRAP = '1;

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_ADD      = 2'd1,
      FUNC_DELETE   = 2'd2,
      FUNC_DISPATCH = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_REPORT
   } seq_state_type;

   // One slot record as stored in the slot memory
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [COUNT_W-1:0]  countdown;
      logic [COUNT_W-1:0]  period;
      logic [COUNT_W-1:0]  pending;
   } slot_rec_type;

   // One result beat
   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  slot_index;
      logic [HANDLE_W-1:0] run_handle;
      logic                last;
   } rsp_beat_type;

endpackage

[design/tts_slot_ram.sv]
// ============================================================================
// tts_slot_ram
// Slot record memory: one write port, one read port, registered read data.
// ============================================================================
module tts_slot_ram import tts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output slot_rec_type        rd_data,
   input  logic                wr_en,
   input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  slot_rec_type        wr_data
);

   slot_rec_type slot_mem [SLOTS];
   slot_rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tts_out_reg.sv]
// ============================================================================
// tts_out_reg
// Output register between the sequencer and the result channel.
// ============================================================================
module tts_out_reg import tts_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_beat_type in_beat,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_beat_type out_beat
);

   logic         full_ff;
   logic         full_in;
   rsp_beat_type beat_ff;

   assign in_ready = !full_ff || out_ready;
   assign full_in  = (in_valid && in_ready) || (full_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   // load a new beat whenever the register frees up
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

   assign out_valid = full_ff;
   assign out_beat  = beat_ff;

endmodule

[design/tts_seq.sv]
// ============================================================================
// tts_seq
// Command sequencer: valid and pending marks, slot scans, result beats.
// ============================================================================
module tts_seq import tts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  func_type            req_func,
   input  logic [2:0]          req_task_slot,
   input  logic [HANDLE_W-1:0] req_task_handle,
   input  logic [COUNT_W-1:0]  req_first_delay,
   input  logic [COUNT_W-1:0]  req_repeat_period,
   output logic                ram_rd_en,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_rd_addr,
   input  slot_rec_type        ram_rd_data,
   output logic                ram_wr_en,
   output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] ram_wr_addr,
   output slot_rec_type        ram_wr_data,
   output logic                emit_valid,
   input  logic                emit_ready,
   output rsp_beat_type        emit_beat
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SW-1:0]      LAST_IDX  = SW'(SLOTS - 1);
   localparam logic [INDEX_W-1:0] NONE_IDX  = INDEX_W'(SLOTS);

   seq_state_type      state_ff, state_in;
   func_type           op_ff, op_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [SLOTS-1:0]   pnz_ff, pnz_in;      // pending count nonzero
   status_type         res_status_ff, res_status_in;
   logic [INDEX_W-1:0] res_slot_ff, res_slot_in;

   logic [SLOTS-1:0]   due;
   logic               free_found;
   logic [SW-1:0]      free_idx;
   logic               due_above;
   logic               advance;
   logic               del_in_range;
   logic [SW-1:0]      del_idx;
   slot_rec_type       rec;

   assign due          = valid_ff & pnz_ff;
   assign del_in_range = 32'(req_task_slot) < SLOTS;
   assign del_idx      = SW'(req_task_slot);
   assign rec          = ram_rd_data;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int j = SLOTS - 1; j >= 0; j--) begin
         if (!valid_ff[j]) begin
            free_found = 1'b1;
            free_idx   = SW'(j);
         end
      end
   end

   // any due slot beyond the one under scan
   always_comb begin
      due_above = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if ((SW'(j) > idx_ff) && due[j]) begin
            due_above = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         valid_ff <= '0;
         pnz_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         pnz_ff   <= pnz_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      valid_in      = valid_ff;
      pnz_in        = pnz_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      req_ready     = 1'b0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = idx_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = idx_ff;
      ram_wr_data   = rec;
      emit_valid    = 1'b0;
      emit_beat     = '0;
      advance       = 1'b0;

      unique case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in = req_func;
               unique case (req_func)
                  FUNC_TICK: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = '0;
                     idx_in      = '0;
                     state_in    = SEQ_SCAN;
                  end
                  FUNC_ADD: begin
                     state_in = SEQ_REPORT;
                     if (free_found) begin
                        ram_wr_en             = 1'b1;
                        ram_wr_addr           = free_idx;
                        ram_wr_data.handle    = req_task_handle;
                        ram_wr_data.countdown = req_first_delay;
                        ram_wr_data.period    = req_repeat_period;
                        ram_wr_data.pending   = '0;
                        valid_in[free_idx]    = 1'b1;
                        pnz_in[free_idx]      = 1'b0;
                        res_status_in         = ST_OK;
                        res_slot_in           = INDEX_W'(free_idx);
                     end else begin
                        res_status_in = ST_FULL;
                        res_slot_in   = NONE_IDX;
                     end
                  end
                  FUNC_DELETE: begin
                     state_in      = SEQ_REPORT;
                     res_slot_in   = INDEX_W'(req_task_slot);
                     res_status_in = ST_EMPTY;
                     if (del_in_range) begin
                        if (valid_ff[del_idx]) begin
                           res_status_in = ST_OK;
                        end
                        valid_in[del_idx] = 1'b0;
                        pnz_in[del_idx]   = 1'b0;
                     end
                  end
                  FUNC_DISPATCH: begin
                     if (|due) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        idx_in      = '0;
                        state_in    = SEQ_SCAN;
                     end else begin
                        res_status_in = ST_NONE;
                        res_slot_in   = NONE_IDX;
                        state_in      = SEQ_REPORT;
                     end
                  end
                  default: begin
                     state_in = SEQ_IDLE;
                  end
               endcase
            end
         end

         SEQ_SCAN: begin
            priority if (op_ff == FUNC_TICK) begin
               advance = 1'b1;
               if (valid_ff[idx_ff]) begin
                  ram_wr_en = 1'b1;
                  if (rec.countdown == '0) begin
                     ram_wr_data.pending   = rec.pending + 1'b1;
                     ram_wr_data.countdown = (rec.period != '0) ? rec.period : CD_WRAP;
                     pnz_in[idx_ff]        = (rec.pending != CD_WRAP);
                  end else begin
                     ram_wr_data.countdown = rec.countdown - 1'b1;
                  end
               end
            end else begin
               if (due[idx_ff]) begin
                  emit_valid           = 1'b1;
                  emit_beat.status     = ST_OK;
                  emit_beat.slot_index = INDEX_W'(idx_ff);
                  emit_beat.run_handle = rec.handle;
                  emit_beat.last       = !due_above;
                  advance              = emit_ready;
                  if (emit_ready) begin
                     if (rec.period == '0) begin
                        // one-shot: drop the slot with any runs still owed
                        valid_in[idx_ff] = 1'b0;
                        pnz_in[idx_ff]   = 1'b0;
                     end else begin
                        ram_wr_en           = 1'b1;
                        ram_wr_data.pending = rec.pending - 1'b1;
                        pnz_in[idx_ff]      = (rec.pending != COUNT_W'(1));
                     end
                  end
               end else begin
                  advance = 1'b1;
               end
            end

            if (advance) begin
               if (idx_ff == LAST_IDX) begin
                  if (op_ff == FUNC_TICK) begin
                     res_status_in = ST_OK;
                     res_slot_in   = NONE_IDX;
                     state_in      = SEQ_REPORT;
                  end else begin
                     state_in = SEQ_IDLE;
                  end
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = idx_ff + 1'b1;
                  idx_in      = idx_ff + 1'b1;
               end
            end
         end

         SEQ_REPORT: begin
            emit_valid           = 1'b1;
            emit_beat.status     = res_status_ff;
            emit_beat.slot_index = res_slot_ff;
            emit_beat.run_handle = '0;
            emit_beat.last       = 1'b1;
            if (emit_ready) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

endmodule

[design/tick_task_scheduler_table_top.sv]
// ============================================================================
// tick_task_scheduler_table_top
// Time-triggered cooperative scheduler: a table of task slots with tick,
// add, delete and dispatch commands on one stream, results on another.
// ============================================================================
// Order: add, delete and nothing-due dispatch record their result, then the
//   report state loads the beat into the output register; tick walks every
//   slot first, and dispatch loads a due slot's beat as the scan reaches it.
// Throughput: tick scans the slot memory one slot per cycle; dispatch with due
//   slots scans the same way but holds on a result stall; no new command is
//   taken until the current command is finished.
// Reset: clears the valid and pending marks at once; no memory clearing pass.
module tick_task_scheduler_table_top import tts_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] func, [4:2] task_slot, [20:5] task_handle, [36:21] first_delay,
   // [52:37] repeat_period, [55:53] zero
   input  logic [55:0] req_tdata,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [5:2] slot_index, [21:6] run_handle, [23:22] zero
   output logic [23:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // slot memory port
   logic          ram_rd_en;
   logic [SW-1:0] ram_rd_addr;
   slot_rec_type  ram_rd_data;
   logic          ram_wr_en;
   logic [SW-1:0] ram_wr_addr;
   slot_rec_type  ram_wr_data;

   // sequencer to output register
   logic          emit_valid;
   logic          emit_ready;
   rsp_beat_type  emit_beat;
   rsp_beat_type  rsp_beat;

   // unpack the command beat
   func_type            req_func;
   logic [2:0]          req_task_slot;
   logic [HANDLE_W-1:0] req_task_handle;
   logic [COUNT_W-1:0]  req_first_delay;
   logic [COUNT_W-1:0]  req_repeat_period;

   assign req_func          = func_type'(req_tdata[1:0]);
   assign req_task_slot     = req_tdata[4:2];
   assign req_task_handle   = req_tdata[20:5];
   assign req_first_delay   = req_tdata[36:21];
   assign req_repeat_period = req_tdata[52:37];

   // the sequencer owns the command channel; it walks the slots for tick and
   // dispatch and handles add and delete from the valid marks alone
   tts_seq #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_func          (req_func),
      .req_task_slot     (req_task_slot),
      .req_task_handle   (req_task_handle),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .emit_valid        (emit_valid),
      .emit_ready        (emit_ready),
      .emit_beat         (emit_beat)
   );

   // slot records; an invalid slot's record is never read for a result
   tts_slot_ram #(
      .SLOTS (SLOTS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   // hold a finished beat so the sequencer can move on
   tts_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (emit_valid),
      .in_ready  (emit_ready),
      .in_beat   (emit_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (rsp_beat)
   );

   // pack the result beat
   assign rsp_tdata = {2'b00, rsp_beat.run_handle, rsp_beat.slot_index, rsp_beat.status};
   assign rsp_tlast = rsp_beat.last;

   // the scan writes one slot while it reads the next: never the same entry
   assert property (@(posedge clock) disable iff (reset)
      (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr))
      else $error("slot memory read and write hit the same entry");

   // no command beat is taken back to back with the one before
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("command taken while the previous one is still in work");

   // every result beat that names no slot closes its command
   assert property (@(posedge clock) disable iff (reset)
      (emit_valid && (emit_beat.status != ST_OK || emit_beat.run_handle == '0)
       && emit_beat.slot_index == INDEX_W'(SLOTS) && SLOTS < 16) |-> emit_beat.last)
      else $error("final result beat without last");

endmodule

[verif/tick_task_scheduler_table_top_tb.sv]
// ============================================================================
// tick_task_scheduler_table_top_tb
// Drives tick, add, delete and dispatch commands into the scheduler table and
// checks every result beat against a cycle-free model of the slot table kept
// in this bench. Covers empty and full tables, one-shot and periodic tasks,
// countdown of a parked one-shot task, long result back-pressure and a
// random command mix with random gaps on both streams.
// ============================================================================
module tick_task_scheduler_table_top_tb;
   import tts_pkg::*;

   localparam int SLOTS      = SLOTS_DEFAULT;
   localparam int HALF_CLOCK = 6;
   // far beyond the slowest legal run with every stall
   localparam longint RUN_LIMIT = 64'd12 * 64'd500_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // [1:0] func, [4:2] task_slot, [20:5] task_handle, [36:21] first_delay,
   // [52:37] repeat_period, [55:53] zero
   logic [55:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [1:0] status, [5:2] slot_index, [21:6] run_handle, [23:22] zero
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;

   tick_task_scheduler_table_top #(.SLOTS(SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #HALF_CLOCK clock = 1'b1;
      #HALF_CLOCK clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Slot table as the bench sees it, and the result beats it still owes
   // ------------------------------------------------------------------------
   logic                tbl_valid     [SLOTS];
   logic [HANDLE_W-1:0] tbl_handle    [SLOTS];
   logic [COUNT_W-1:0]  tbl_countdown [SLOTS];
   logic [COUNT_W-1:0]  tbl_period    [SLOTS];
   logic [COUNT_W-1:0]  tbl_pending   [SLOTS];
   logic                table_err;

   rsp_beat_type result_q[$];

   int errors       = 0;
   int hold_left    = 0;   // long receiver hold-off, loaded by a test
   int stall_left   = 0;
   bit send_idle_on = 1'b1;
   bit recv_idle_on = 1'b1;

   task automatic clear_slot(input int s);
      tbl_valid[s]     = 1'b0;
      tbl_handle[s]    = '0;
      tbl_countdown[s] = '0;
      tbl_period[s]    = '0;
      tbl_pending[s]   = '0;
   endtask

   function automatic rsp_beat_type make_beat(input status_type st, input int idx,
                                              input logic [HANDLE_W-1:0] h,
                                              input logic l);
      rsp_beat_type b;
      b.status     = st;
      b.slot_index = idx[INDEX_W-1:0];
      b.run_handle = h;
      b.last       = l;
      return b;
   endfunction

   // Apply one accepted command to the table and queue the beats it owes.
   task automatic scheduler_step(input func_type f, input logic [2:0] tslot,
                                 input logic [HANDLE_W-1:0] h,
                                 input logic [COUNT_W-1:0] delay,
                                 input logic [COUNT_W-1:0] period);
      int s;
      int due;
      int k;
      case (f)
         FUNC_TICK: begin
            for (s = 0; s < SLOTS; s++) begin
               if (!tbl_valid[s]) continue;
               if (tbl_countdown[s] == '0) begin
                  tbl_pending[s]   = tbl_pending[s] + 1'b1;
                  // one-shot tasks park at the wrap value until dispatched
                  tbl_countdown[s] = (tbl_period[s] != '0) ? tbl_period[s] : CD_WRAP;
               end else begin
                  tbl_countdown[s] = tbl_countdown[s] - 1'b1;
               end
            end
            result_q.push_back(make_beat(ST_OK, SLOTS, '0, 1'b1));
         end
         FUNC_ADD: begin
            for (s = 0; s < SLOTS; s++)
               if (!tbl_valid[s]) break;
            if (s >= SLOTS) begin
               table_err = 1'b1;
               result_q.push_back(make_beat(ST_FULL, SLOTS, '0, 1'b1));
            end else begin
               tbl_valid[s]     = 1'b1;
               tbl_handle[s]    = h;
               tbl_countdown[s] = delay;
               tbl_period[s]    = period;
               tbl_pending[s]   = '0;
               result_q.push_back(make_beat(ST_OK, s, '0, 1'b1));
            end
         end
         FUNC_DELETE: begin
            // a slot number beyond the table reads as an empty slot
            if (int'(tslot) < SLOTS && tbl_valid[tslot]) begin
               result_q.push_back(make_beat(ST_OK, tslot, '0, 1'b1));
            end else begin
               table_err = 1'b0;
               result_q.push_back(make_beat(ST_EMPTY, tslot, '0, 1'b1));
            end
            if (int'(tslot) < SLOTS) clear_slot(tslot);
         end
         default: begin
            // a slot's dispatch only touches that slot, so count the due ones first
            due = 0;
            for (s = 0; s < SLOTS; s++)
               if (tbl_pending[s] != '0) due++;
            if (due == 0) begin
               result_q.push_back(make_beat(ST_NONE, SLOTS, '0, 1'b1));
            end else begin
               k = 0;
               for (s = 0; s < SLOTS; s++) begin
                  if (tbl_pending[s] == '0) continue;
                  k++;
                  result_q.push_back(make_beat(ST_OK, s, tbl_handle[s], k == due));
                  tbl_pending[s] = tbl_pending[s] - 1'b1;
                  // one-shot: drop the slot and any runs still pending
                  if (tbl_period[s] == '0) clear_slot(s);
               end
            end
         end
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Gap lengths: mostly none, often short, now and then long
   // ------------------------------------------------------------------------
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Command side: called and returning at a rising edge
   // ------------------------------------------------------------------------
   task automatic issue_cmd(input func_type f, input logic [2:0] tslot,
                            input logic [HANDLE_W-1:0] h,
                            input logic [COUNT_W-1:0] delay,
                            input logic [COUNT_W-1:0] period);
      int gap;
      gap = send_idle_on ? gap_len() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, period, delay, h, tslot, f};
      // hold the beat until the block takes it
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scheduler_step(f, tslot, h, delay, period);
   endtask

   // unused fields carry noise; the block must ignore them
   task automatic do_tick();
      issue_cmd(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic do_add(input logic [15:0] h, input logic [15:0] delay,
                         input logic [15:0] period);
      issue_cmd(FUNC_ADD, 3'($urandom), h, delay, period);
   endtask

   task automatic do_delete(input logic [2:0] tslot);
      issue_cmd(FUNC_DELETE, tslot, 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic do_dispatch();
      issue_cmd(FUNC_DISPATCH, 3'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Result side: check each beat, then pick next cycle's ready
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("%0t mismatch on %s: want 0x%0h got 0x%0h", $time, what, want, got);
      errors++;
   endtask

   task automatic check_beat();
      rsp_beat_type want;
      if (result_q.size() == 0) begin
         report_mismatch("unexpected beat", 0, rsp_tdata);
         return;
      end
      want = result_q.pop_front();
      if (rsp_tdata[1:0] != want.status)
         report_mismatch("status", want.status, rsp_tdata[1:0]);
      if (rsp_tdata[5:2] != want.slot_index)
         report_mismatch("slot_index", want.slot_index, rsp_tdata[5:2]);
      if (rsp_tdata[21:6] != want.run_handle)
         report_mismatch("run_handle", want.run_handle, rsp_tdata[21:6]);
      if (rsp_tlast != want.last)
         report_mismatch("tlast", want.last, rsp_tlast);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (hold_left > 0) begin
            // long hold-off: let the block back up into its command port
            hold_left  = hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (recv_idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_empty_table();
      do_tick();
      do_dispatch();          // nothing due
      do_delete(3'd0);        // delete of an empty slot
      do_delete(3'd7);
   endtask

   task automatic test_one_shot();
      do_add(16'h0000, 16'h0000, 16'h0000);   // handle 0 is a real task
      do_tick();
      do_dispatch();                          // runs and deletes the one-shot
      do_dispatch();
      do_delete(3'd0);                        // already gone
      do_add(16'hFFFF, 16'h0001, 16'hFFFF);
      do_tick();
      do_tick();
      do_dispatch();
      do_delete(3'd0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < SLOTS; i++)
         do_add(16'(16'h1000 + i), 16'(i % 3), 16'(i % 2));
      do_add(16'hBEEF, 16'h0000, 16'h0001);   // table full
      do_delete(3'd3);
      do_add(16'h3333, 16'h0000, 16'h0000);   // reuses the lowest free slot
      do_tick();
      do_tick();
      do_dispatch();                          // several beats in slot order
      for (int s = 0; s < SLOTS; s++) do_delete(3'(s));
   endtask

   task automatic test_backpressure();
      hold_left = 300;
      for (int s = 0; s < SLOTS; s++)
         do_add(16'(16'hC000 + s), 16'h0000, 16'h0001);
      for (int i = 0; i < 4; i++) begin
         do_tick();
         do_dispatch();
      end
      for (int s = 0; s < SLOTS; s++) do_delete(3'(s));
   endtask

   task automatic test_countdown_wrap();
      bit keep_send;
      bit keep_recv;
      keep_send    = send_idle_on;
      keep_recv    = recv_idle_on;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      for (int s = 0; s < SLOTS; s++) do_delete(3'(s));
      do_add(16'h5A5A, 16'h0000, 16'h0000);   // one-shot, parks at 0xFFFF after firing
      do_add(16'hA5A5, 16'h0000, 16'h0001);
      do_add(16'h0F0F, 16'hFFFF, 16'hFFFF);
      // the parked one-shot counts down from the wrap value without firing again
      repeat (6) do_tick();
      do_dispatch();
      do_dispatch();
      for (int s = 0; s < SLOTS; s++) do_delete(3'(s));
      send_idle_on = keep_send;
      recv_idle_on = keep_recv;
   endtask

   task automatic test_random_mix();
      int r;
      logic [15:0] delay;
      logic [15:0] period;
      for (int i = 0; i < 85; i++) begin
         if (i % 40 == 0) begin
            // some stretches run without any gaps
            send_idle_on = ($urandom_range(0, 2) != 0);
            recv_idle_on = ($urandom_range(0, 2) != 0);
         end
         r = $urandom_range(0, 99);
         if (r < 40) begin
            do_tick();
         end else if (r < 65) begin
            r = $urandom_range(0, 9);
            delay  = (r < 7) ? 16'($urandom_range(0, 4)) :
                     (r < 9) ? 16'($urandom_range(0, 30)) : 16'($urandom);
            r = $urandom_range(0, 9);
            period = (r < 3) ? 16'h0000 :
                     (r < 7) ? 16'($urandom_range(1, 4)) :
                     (r < 9) ? 16'($urandom_range(5, 20)) : 16'($urandom);
            do_add(16'($urandom), delay, period);
         end else if (r < 80) begin
            do_delete(3'($urandom_range(0, SLOTS - 1)));
         end else begin
            do_dispatch();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      for (int s = 0; s < SLOTS; s++) clear_slot(s);
      table_err = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_one_shot();
      test_full_table();
      test_backpressure();
      test_countdown_wrap();
      test_random_mix();

      // drop valid and let the last beats drain
      req_tvalid   <= 1'b0;
      send_idle_on = 1'b0;
      recv_idle_on = 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (2 * SLOTS + 10) @(posedge clock);

      if (errors == 0) begin
         $display("tick_task_scheduler_table_top_tb: clean");
      end else begin
         $display("tick_task_scheduler_table_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("tick_task_scheduler_table_top_tb: errors");
      $finish;
   end

endmodule
